// ===== rtl/mspt_pkg.sv =====
package mspt_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_CREATE  = 3'd0;
    localparam logic [2:0] REQ_START   = 3'd1;
    localparam logic [2:0] REQ_RESET   = 3'd2;
    localparam logic [2:0] REQ_STOP    = 3'd3;
    localparam logic [2:0] REQ_DESTROY = 3'd4;
    localparam logic [2:0] REQ_TICK    = 3'd5;

    // Result kinds
    localparam logic EV_ACK  = 1'b0;
    localparam logic EV_FIRE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  slot_index;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic        repeat_req;
    } req_t;

    typedef struct packed {
        logic       event_kind;
        logic [2:0] slot_out;
        logic [1:0] status;
        logic       last_result;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        out_of_range;
        logic [2:0]  slot_index;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic        repeat_req;
    } cmd_t;

endpackage

// ===== rtl/mspt_front.sv =====
module mspt_front #(
    parameter int SLOT_COUNT = 5
) (
    input  mspt_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_ready,
    input  logic           q_ready,
    output logic           q_push,
    output mspt_pkg::cmd_t q_cmd
);

    logic known;

    // Classify: drop unknown request codes, flag out-of-range slot indexes
    always_comb
    begin
        unique case (req.req_type) inside
            mspt_pkg::REQ_CREATE, mspt_pkg::REQ_START, mspt_pkg::REQ_RESET,
            mspt_pkg::REQ_STOP, mspt_pkg::REQ_DESTROY, mspt_pkg::REQ_TICK:
                known = 1'b1;
            default:
                known = 1'b0;
        endcase
    end

    assign req_ready = q_ready;
    assign q_push    = req_valid && q_ready && known;

    always_comb
    begin
        q_cmd.op           = req.req_type;
        q_cmd.out_of_range = (32'(req.slot_index) >= 32'(SLOT_COUNT));
        q_cmd.slot_index   = req.slot_index;
        q_cmd.now_ms       = req.now_ms;
        q_cmd.period_ms    = req.period_ms;
        q_cmd.repeat_req   = req.repeat_req;
    end

endmodule

// ===== rtl/mspt_queue.sv =====
module mspt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mspt_pkg::cmd_t push_cmd,
    output logic           ready,
    output logic           valid,
    output mspt_pkg::cmd_t head,
    input  logic           pop
);

    localparam int PTR_W = (mspt_pkg::QUEUE_DEPTH > 1) ? $clog2(mspt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mspt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mspt_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(mspt_pkg::QUEUE_DEPTH);

    mspt_pkg::cmd_t   entry_reg [mspt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != FULL_CNT);
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/mspt_back.sv =====
module mspt_back #(
    parameter int SLOT_COUNT = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  mspt_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mspt_pkg::rsp_t rsp
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ELAPSED = 3'd1;
    localparam logic [2:0] S_CHECK   = 3'd2;
    localparam logic [2:0] S_UPDATE  = 3'd3;
    localparam logic [2:0] S_FLUSH   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [SW-1:0] ptr_reg, ptr_next;
    logic [31:0] now_reg, now_next;
    logic held_valid_reg, held_valid_next;
    logic [SW-1:0] held_slot_reg, held_slot_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [31:0] eff_dl_reg, eff_dl_next;

    logic [SLOT_COUNT-1:0] alloc_reg, alloc_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [SLOT_COUNT-1:0] repeat_reg, repeat_next;
    logic [SLOT_COUNT-1:0] fired_reg, fired_next;
    logic [31:0] period_reg [SLOT_COUNT];
    logic [31:0] deadline_reg [SLOT_COUNT];
    logic [31:0] last_reg [SLOT_COUNT];

    logic rsp_valid_reg, rsp_valid_next;
    mspt_pkg::rsp_t rsp_reg;

    logic [SW-1:0] head_addr, rd_addr, wr_addr, pick;
    logic found;
    logic [31:0] rd_period, rd_deadline, rd_last;
    logic [31:0] arm_sum, new_dl;
    logic per_we, dl_we, lt_we;
    logic [31:0] per_wdata, dl_wdata, lt_wdata;
    logic can_emit, emit;
    mspt_pkg::rsp_t emit_rsp;
    logic skip, force_dl, fire;

    assign head_addr   = SW'(cmd.slot_index);
    assign rd_addr     = (state_reg == S_IDLE) ? head_addr : ptr_reg;
    assign rd_period   = period_reg[rd_addr];
    assign rd_deadline = deadline_reg[ptr_reg];
    assign rd_last     = last_reg[ptr_reg];
    assign can_emit    = !rsp_valid_reg || rsp_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    // Highest-numbered free slot
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!alloc_reg[i])
            begin
                found = 1'b1;
                pick  = SW'(i);
            end
        end
    end

    assign arm_sum = cmd.now_ms + ((cmd.op == mspt_pkg::REQ_START) ? rd_period : cmd.period_ms);
    assign new_dl  = eff_dl_reg + rd_period;

    assign skip     = !alloc_reg[ptr_reg] || !active_reg[ptr_reg]
                      || (!repeat_reg[ptr_reg] && fired_reg[ptr_reg]);
    assign force_dl = repeat_reg[ptr_reg] && (elapsed_reg >= rd_period);
    assign fire     = force_dl || (now_reg >= rd_deadline) || (now_reg < rd_last);

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        now_next        = now_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        elapsed_next    = elapsed_reg;
        eff_dl_next     = eff_dl_reg;
        alloc_next      = alloc_reg;
        active_next     = active_reg;
        repeat_next     = repeat_reg;
        fired_next      = fired_reg;
        wr_addr         = head_addr;
        per_we          = 1'b0;
        dl_we           = 1'b0;
        lt_we           = 1'b0;
        per_wdata       = cmd.period_ms;
        dl_wdata        = arm_sum;
        lt_wdata        = cmd.now_ms;
        cmd_pop         = 1'b0;
        emit            = 1'b0;
        emit_rsp        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.op == mspt_pkg::REQ_TICK)
                begin
                    cmd_pop         = 1'b1;
                    ptr_next        = '0;
                    now_next        = cmd.now_ms;
                    held_valid_next = 1'b0;
                    state_next      = S_ELAPSED;
                end
                else if (cmd_valid && can_emit)
                begin
                    cmd_pop              = 1'b1;
                    emit                 = 1'b1;
                    emit_rsp.event_kind  = mspt_pkg::EV_ACK;
                    emit_rsp.last_result = 1'b1;
                    emit_rsp.slot_out    = cmd.slot_index;
                    emit_rsp.status      = mspt_pkg::ST_OK;
                    if (cmd.op == mspt_pkg::REQ_CREATE)
                    begin
                        if (found)
                        begin
                            wr_addr            = pick;
                            alloc_next[pick]   = 1'b1;
                            active_next[pick]  = 1'b0;
                            fired_next[pick]   = 1'b0;
                            repeat_next[pick]  = cmd.repeat_req;
                            per_we             = 1'b1;
                            dl_we              = 1'b1;
                            lt_we              = 1'b1;
                            emit_rsp.slot_out  = 3'(pick);
                        end
                        else
                        begin
                            emit_rsp.slot_out = '0;
                            emit_rsp.status   = mspt_pkg::ST_NO_FREE;
                        end
                    end
                    else if (cmd.out_of_range)
                    begin
                        emit_rsp.status = mspt_pkg::ST_RANGE;
                    end
                    else
                    begin
                        case (cmd.op)
                            mspt_pkg::REQ_START:
                            begin
                                dl_we                  = 1'b1;
                                lt_we                  = 1'b1;
                                fired_next[head_addr]  = 1'b0;
                                active_next[head_addr] = 1'b1;
                            end
                            mspt_pkg::REQ_RESET:
                            begin
                                per_we                = 1'b1;
                                dl_we                 = 1'b1;
                                lt_we                 = 1'b1;
                                fired_next[head_addr] = 1'b0;
                            end
                            mspt_pkg::REQ_STOP:
                            begin
                                active_next[head_addr] = 1'b0;
                            end
                            default:
                            begin
                                alloc_next[head_addr]  = 1'b0;
                                active_next[head_addr] = 1'b0;
                            end
                        endcase
                    end
                end
            end

            S_ELAPSED:
            begin
                elapsed_next = (rd_last <= now_reg) ? now_reg - rd_last : rd_last - now_reg;
                if (!skip)
                begin
                    state_next = S_CHECK;
                end
                else if (ptr_reg == LAST_SLOT)
                begin
                    state_next = held_valid_reg ? S_FLUSH : S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_CHECK:
            begin
                eff_dl_next = force_dl ? now_reg : rd_deadline;
                if (fire)
                begin
                    state_next = S_UPDATE;
                end
                else if (ptr_reg == LAST_SLOT)
                begin
                    state_next = held_valid_reg ? S_FLUSH : S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_ELAPSED;
                end
            end

            S_UPDATE:
            begin
                if (!held_valid_reg || can_emit)
                begin
                    wr_addr             = ptr_reg;
                    dl_we               = 1'b1;
                    dl_wdata            = new_dl;
                    lt_we               = 1'b1;
                    lt_wdata            = (new_dl < now_reg) ? '0 : now_reg;
                    fired_next[ptr_reg] = 1'b1;
                    if (held_valid_reg)
                    begin
                        emit                 = 1'b1;
                        emit_rsp.event_kind  = mspt_pkg::EV_FIRE;
                        emit_rsp.slot_out    = 3'(held_slot_reg);
                        emit_rsp.status      = mspt_pkg::ST_OK;
                        emit_rsp.last_result = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_slot_next  = ptr_reg;
                    if (ptr_reg == LAST_SLOT)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = S_ELAPSED;
                    end
                end
            end

            S_FLUSH:
            begin
                if (can_emit)
                begin
                    emit                 = 1'b1;
                    emit_rsp.event_kind  = mspt_pkg::EV_FIRE;
                    emit_rsp.slot_out    = 3'(held_slot_reg);
                    emit_rsp.status      = mspt_pkg::ST_OK;
                    emit_rsp.last_result = 1'b1;
                    held_valid_next      = 1'b0;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            held_valid_reg <= 1'b0;
            alloc_reg      <= '0;
            active_reg     <= '0;
            repeat_reg     <= '0;
            fired_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                period_reg[i]   <= '0;
                deadline_reg[i] <= '0;
                last_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            held_valid_reg <= held_valid_next;
            alloc_reg      <= alloc_next;
            active_reg     <= active_next;
            repeat_reg     <= repeat_next;
            fired_reg      <= fired_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (per_we)
            begin
                period_reg[wr_addr] <= per_wdata;
            end
            if (dl_we)
            begin
                deadline_reg[wr_addr] <= dl_wdata;
            end
            if (lt_we)
            begin
                last_reg[wr_addr] <= lt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        held_slot_reg <= held_slot_next;
        elapsed_reg   <= elapsed_next;
        eff_dl_reg    <= eff_dl_next;
        if (emit)
        begin
            rsp_reg <= emit_rsp;
        end
    end

endmodule

// ===== rtl/multi_slot_periodic_timer.sv =====
// Channel | Direction | Handshake            | Beat payload
// req     | in        | req_valid/req_ready  | mspt_pkg::req_t (type, slot, now, period, repeat)
// rsp     | out       | rsp_valid/rsp_ready  | mspt_pkg::rsp_t (kind, slot, status, last)
//
// Each request beat is classified on entry and held in a two-entry command queue,
// so a new beat is taken while the back end works or a result waits at the output.
// Acknowledge requests are answered straight from the idle state. A tick walks the
// slots one at a time: a skipped slot passes through the elapsed step only, a slot
// that is not due through the elapsed and check steps, and a slot that fires through
// elapsed, check and update; a flush step then delivers the final fire.
// Reset clears every slot at once; no clearing pass follows.
// A stalled result output holds the back end only when it has another beat to emit.
module multi_slot_periodic_timer #(
    parameter int SLOT_COUNT = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mspt_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_ready,
    output mspt_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_ready
);

    logic           q_push;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    mspt_pkg::cmd_t q_cmd;
    mspt_pkg::cmd_t q_head;

    // Classify request beats and drop unknown codes
    mspt_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Decouple intake from execution
    mspt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .ready    (q_ready),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    // Slot table, tick walker and result register
    mspt_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("command queue popped while empty");

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> q_ready)
        else $error("command queue pushed while full");

    // Every acknowledge is the final beat of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.event_kind == mspt_pkg::EV_ACK) |-> rsp.last_result)
        else $error("acknowledge without last_result");

    // A fire always reports status ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.event_kind == mspt_pkg::EV_FIRE) |-> (rsp.status == mspt_pkg::ST_OK))
        else $error("fire beat with non-ok status");

endmodule

// ===== tb/tb_multi_slot_periodic_timer.sv =====
module tb_multi_slot_periodic_timer;

    localparam int SLOT_COUNT  = 5;
    // Any quiet stretch longer than this means the block has hung
    localparam int QUIET_LIMIT = 2000;
    // Request codes with no meaning; the block must drop them silently
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // Result receiver behaviour, changed after each random stretch
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    mspt_pkg::req_t req = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    mspt_pkg::rsp_t rsp;
    logic rsp_valid;
    logic rsp_ready = 1'b0;

    // Shadow copy of the slot table, updated as each request beat is taken
    logic        shadow_alloc    [SLOT_COUNT];
    logic        shadow_active   [SLOT_COUNT];
    logic        shadow_periodic [SLOT_COUNT];
    logic        shadow_done     [SLOT_COUNT];
    logic [31:0] shadow_period   [SLOT_COUNT];
    logic [31:0] shadow_due      [SLOT_COUNT];
    logic [31:0] shadow_last     [SLOT_COUNT];

    // Result beats still owed by the block, oldest first
    mspt_pkg::rsp_t pending_events[$];
    mspt_pkg::rsp_t want_beat;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int burst_left = 1;

    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;

    multi_slot_periodic_timer #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .rsp(rsp),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready)
    );

    always #5 clk = ~clk;

    function automatic mspt_pkg::rsp_t make_beat(input logic kind, input logic [2:0] slot,
                                                 input logic [1:0] code, input logic last);
        mspt_pkg::rsp_t b;
        b.event_kind = kind;
        b.slot_out = slot;
        b.status = code;
        b.last_result = last;
        return b;
    endfunction

    function automatic mspt_pkg::req_t make_req(input logic [2:0] kind, input logic [2:0] idx,
                                                input logic [31:0] now,
                                                input logic [31:0] period,
                                                input logic rep);
        mspt_pkg::req_t r;
        r.req_type = kind;
        r.slot_index = idx;
        r.now_ms = now;
        r.period_ms = period;
        r.repeat_req = rep;
        return r;
    endfunction

    // Rearm a slot: restart its elapsed-time reference and push the deadline out
    function automatic void rearm_slot(input int s, input logic [31:0] now,
                                       input logic [31:0] period);
        shadow_last[s] = now;
        shadow_due[s] = now + period;
        shadow_done[s] = 1'b0;
    endfunction

    // Apply one request beat to the shadow table and queue the beats it owes
    function automatic void predict_timer_events(input mspt_pkg::req_t r);
        mspt_pkg::rsp_t held;
        logic have_held;
        logic found;
        int pick;
        int s;
        logic [31:0] elapsed;
        held = '0;
        have_held = 1'b0;
        found = 1'b0;
        pick = 0;
        case (r.req_type) inside
            mspt_pkg::REQ_CREATE:
            begin
                // Highest-numbered free slot wins
                for (s = 0; s < SLOT_COUNT; s++)
                begin
                    if (!shadow_alloc[s])
                    begin
                        pick = s;
                        found = 1'b1;
                    end
                end
                if (!found)
                    pending_events.push_back(make_beat(mspt_pkg::EV_ACK, 3'd0,
                                                       mspt_pkg::ST_NO_FREE, 1'b1));
                else
                begin
                    shadow_alloc[pick] = 1'b1;
                    shadow_active[pick] = 1'b0;
                    shadow_periodic[pick] = r.repeat_req;
                    shadow_period[pick] = r.period_ms;
                    rearm_slot(pick, r.now_ms, r.period_ms);
                    pending_events.push_back(make_beat(mspt_pkg::EV_ACK, 3'(pick),
                                                       mspt_pkg::ST_OK, 1'b1));
                end
            end
            mspt_pkg::REQ_START, mspt_pkg::REQ_RESET, mspt_pkg::REQ_STOP,
            mspt_pkg::REQ_DESTROY:
            begin
                if (r.slot_index >= SLOT_COUNT)
                    pending_events.push_back(make_beat(mspt_pkg::EV_ACK, r.slot_index,
                                                       mspt_pkg::ST_RANGE, 1'b1));
                else
                begin
                    s = int'(r.slot_index);
                    case (r.req_type)
                        mspt_pkg::REQ_START:
                        begin
                            // Honoured on a free slot too; the tick ignores it there
                            rearm_slot(s, r.now_ms, shadow_period[s]);
                            shadow_active[s] = 1'b1;
                        end
                        mspt_pkg::REQ_RESET:
                        begin
                            shadow_period[s] = r.period_ms;
                            rearm_slot(s, r.now_ms, r.period_ms);
                        end
                        mspt_pkg::REQ_STOP:
                            shadow_active[s] = 1'b0;
                        default:
                        begin
                            shadow_alloc[s] = 1'b0;
                            shadow_active[s] = 1'b0;
                        end
                    endcase
                    pending_events.push_back(make_beat(mspt_pkg::EV_ACK, r.slot_index,
                                                       mspt_pkg::ST_OK, 1'b1));
                end
            end
            mspt_pkg::REQ_TICK:
            begin
                // Hold each fire back one slot so the final one can carry the last flag
                for (s = 0; s < SLOT_COUNT; s++)
                begin
                    if (shadow_alloc[s] && shadow_active[s]
                        && (shadow_periodic[s] || !shadow_done[s]))
                    begin
                        elapsed = (shadow_last[s] <= r.now_ms) ? r.now_ms - shadow_last[s]
                                                               : shadow_last[s] - r.now_ms;
                        if (shadow_periodic[s] && elapsed >= shadow_period[s])
                            shadow_due[s] = r.now_ms;
                        if (r.now_ms >= shadow_due[s] || r.now_ms < shadow_last[s])
                        begin
                            shadow_last[s] = r.now_ms;
                            shadow_due[s] = shadow_due[s] + shadow_period[s];
                            if (shadow_due[s] < r.now_ms)
                                shadow_last[s] = '0;
                            shadow_done[s] = 1'b1;
                            if (have_held)
                                pending_events.push_back(held);
                            held = make_beat(mspt_pkg::EV_FIRE, 3'(s), mspt_pkg::ST_OK, 1'b0);
                            have_held = 1'b1;
                        end
                    end
                end
                if (have_held)
                begin
                    held.last_result = 1'b1;
                    pending_events.push_back(held);
                end
            end
            default:
            begin
                // Spare codes: no state change, no beat
            end
        endcase
    endfunction

    // Offer one request beat and hold it until taken, then maybe idle for a gap.
    // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic send_request(input mspt_pkg::req_t r);
        int gap;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_timer_events(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering beats until every owed result has been taken.
    // Always advance the clock first so valid is never lowered and raised in one step.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // Fill the table: periodic with zero period, one-shot, periodic, periodic
    // with the largest period, one-shot, then one create too many.
    task automatic test_create_until_full();
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd0, 32'd1000, 32'd0, 1'b1));
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd7, 32'd1000, 32'd10, 1'b0));
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd0, 32'd1000, 32'd100, 1'b1));
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd0, 32'd1000, 32'hFFFF_FFFF, 1'b1));
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd0, 32'd1000, 32'd5, 1'b0));
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd0, 32'd1000, 32'd3, 1'b1));
    endtask

    // Every slot-addressed request with an index past the table
    task automatic test_index_range();
        send_request(make_req(mspt_pkg::REQ_START, 3'(SLOT_COUNT), 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_RESET, 3'(SLOT_COUNT + 1), 32'd1000, 32'd7, 1'b1));
        send_request(make_req(mspt_pkg::REQ_STOP, 3'd7, 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_DESTROY, 3'(SLOT_COUNT), 32'd1000, 32'd0, 1'b0));
    endtask

    // Arm four slots and let ticks catch each kind of fire, including a
    // one-shot that must stay quiet once it has gone off
    task automatic test_tick_fires();
        send_request(make_req(mspt_pkg::REQ_START, 3'd4, 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_START, 3'd3, 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_START, 3'd2, 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_START, 3'd1, 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd1000, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd1010, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd1020, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd1200, 32'd0, 1'b0));
    endtask

    // Time running backwards, then the top of the range and the wrap to zero
    task automatic test_time_edges();
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd500, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0, 1'b0));
    endtask

    // Stop, reset, destroy, start on a freed slot, reuse of the freed slot,
    // and the two spare request codes with every field bit set
    task automatic test_slot_lifecycle();
        send_request(make_req(mspt_pkg::REQ_STOP, 3'd2, 32'd50, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_RESET, 3'd3, 32'd50, 32'hFFFF_FFFF, 1'b0));
        send_request(make_req(mspt_pkg::REQ_DESTROY, 3'd0, 32'd50, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_START, 3'd0, 32'd60, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_TICK, 3'd0, 32'd80, 32'd0, 1'b0));
        send_request(make_req(mspt_pkg::REQ_CREATE, 3'd0, 32'd90, 32'd2, 1'b1));
        send_request(make_req(REQ_SPARE_LO, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_request(make_req(REQ_SPARE_HI, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    endtask

    // Mostly a plausible clock walking forward with short periods so slots keep
    // firing; salted with wild times, huge periods, bad indexes and spare codes.
    task automatic test_random_traffic(input int count);
        int sent;
        int roll;
        logic [31:0] cur_ms;
        logic [31:0] now;
        logic [31:0] period;
        logic [2:0] idx;
        logic [2:0] kind;
        logic rep;
        sent = 0;
        cur_ms = 32'd2000;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            cur_ms = cur_ms + $urandom_range(0, 12);
            if ($urandom_range(0, 199) == 0)
                cur_ms = 32'hFFFF_FF80 + $urandom_range(0, 100);
            if ($urandom_range(0, 39) == 0)
                cur_ms = cur_ms - $urandom_range(1, 30);
            now = ($urandom_range(0, 31) == 0) ? $urandom : cur_ms;
            idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(SLOT_COUNT, 7))
                                              : 3'($urandom_range(0, SLOT_COUNT - 1));
            period = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40);
            rep = ($urandom_range(0, 9) < 7);
            if (roll < 40)
                kind = mspt_pkg::REQ_TICK;
            else if (roll < 52)
                kind = mspt_pkg::REQ_CREATE;
            else if (roll < 68)
                kind = mspt_pkg::REQ_START;
            else if (roll < 78)
                kind = mspt_pkg::REQ_RESET;
            else if (roll < 86)
                kind = mspt_pkg::REQ_STOP;
            else if (roll < 95)
                kind = mspt_pkg::REQ_DESTROY;
            else
                kind = ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
            send_request(make_req(kind, idx, now, period, rep));
            if (kind != REQ_SPARE_LO && kind != REQ_SPARE_HI)
                sent++;
            // Let the block run dry once in the middle of the traffic
            if (sent == count / 2 && kind != REQ_SPARE_LO && kind != REQ_SPARE_HI)
                drain_results();
        end
    endtask

    // Receiver: switch between always ready, coin flips, sparse acceptance
    // and a fixed one-in-eight comb, each for a random stretch
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 48);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= ($urandom_range(0, 1) != 0);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= (rx_left[2:0] == 3'd0);
        endcase
    end

    // Compare each result beat, field by field, with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: result kind=%0d slot=%0d status=%0d last=%0d, expected none",
                         $time, rsp.event_kind, rsp.slot_out, rsp.status, rsp.last_result);
                mismatch_count++;
            end
            else
            begin
                want_beat = pending_events.pop_front();
                if (rsp.event_kind !== want_beat.event_kind)
                begin
                    $display("%0t: event_kind expected %0d actual %0d",
                             $time, want_beat.event_kind, rsp.event_kind);
                    mismatch_count++;
                end
                if (rsp.slot_out !== want_beat.slot_out)
                begin
                    $display("%0t: slot_out expected %0d actual %0d",
                             $time, want_beat.slot_out, rsp.slot_out);
                    mismatch_count++;
                end
                if (rsp.status !== want_beat.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_beat.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.last_result !== want_beat.last_result)
                begin
                    $display("%0t: last_result expected %0d actual %0d",
                             $time, want_beat.last_result, rsp.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: any beat on either channel restarts the count
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            shadow_alloc[s] = 1'b0;
            shadow_active[s] = 1'b0;
            shadow_periodic[s] = 1'b0;
            shadow_done[s] = 1'b0;
            shadow_period[s] = '0;
            shadow_due[s] = '0;
            shadow_last[s] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_create_until_full();
        test_index_range();
        test_tick_fires();
        test_time_edges();
        test_slot_lifecycle();
        drain_results();
        test_random_traffic(450);
        drain_results();
        // Allow a trailing tick that owes nothing to finish its walk
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
